### hw/rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 byte converter.
package u8u16_pkg;

  // Default largest buffer, in source bytes, that the output byte count is sized for.
  localparam int unsigned DEFAULT_MAX_BUFFER_BYTES = 65536;

  // The output byte count saturates at twice the buffer size, or at its full range.
  function automatic logic [17:0] count_limit(input int unsigned max_bytes);
    int unsigned limit;
    limit = ((2 * max_bytes) < 32'h3FFFF) ? (2 * max_bytes) : 32'h3FFFF;
    return limit[17:0];
  endfunction

  localparam logic [17:0] COUNT_LIMIT = count_limit(DEFAULT_MAX_BUFFER_BYTES);

  // Lead byte classes, taken from the top nibble.
  localparam logic [3:0] NIB_TWO_BYTE   = 4'hC;
  localparam logic [3:0] NIB_THREE_BYTE = 4'hE;

  // Continuation bytes still expected after each lead class.
  localparam logic [1:0] REM_NONE  = 2'd0;
  localparam logic [1:0] REM_ONE   = 2'd1;
  localparam logic [1:0] REM_TWO   = 2'd2;
  localparam logic [1:0] REM_THREE = 2'd3;

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]  remaining;
    logic [15:0] acc;
    logic [17:0] total;
  } u8u16_state_t;

  // One result item.
  typedef struct packed {
    logic        unit_valid;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic        end_of_buffer;
    logic [17:0] byte_count;
  } u8u16_result_t;

endpackage

### hw/rtl/u8u16_if.sv
// Valid/ready channel interfaces for the input bytes and the result items.
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_in_buffer;

  modport source (output valid, output in_byte, output last_in_buffer, input ready);
  modport sink   (input valid, input in_byte, input last_in_buffer, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic        unit_valid;
  logic [7:0]  first_byte;
  logic [7:0]  second_byte;
  logic        end_of_buffer;
  logic [17:0] byte_count;

  modport source (output valid, output unit_valid, output first_byte, output second_byte,
                  output end_of_buffer, output byte_count, input ready);
  modport sink   (input valid, input unit_valid, input first_byte, input second_byte,
                  input end_of_buffer, input byte_count, output ready);
endinterface

### hw/rtl/u8u16_decode.sv
// Combinational step of the decoder: one UTF-8 byte against the current state.
module u8u16_decode
  import u8u16_pkg::*;
#(
  parameter int unsigned MAX_BUFFER_BYTES = DEFAULT_MAX_BUFFER_BYTES
)
(
  input  u8u16_state_t  state,
  input  logic [7:0]    in_byte,
  input  logic          last_in_buffer,
  input  logic          big_endian,
  output u8u16_state_t  state_next,
  output u8u16_result_t result
);

  localparam logic [17:0] SAT_LIMIT = count_limit(MAX_BUFFER_BYTES);

  logic [3:0]  top;
  logic [15:0] acc_new;
  logic [1:0]  rem_new;
  logic        done;
  logic [18:0] total_sum;
  logic [17:0] total_new;

  assign top = in_byte[7:4];

  // Classify a lead byte or shift in a continuation byte.
  always_comb begin
    done    = 1'b0;
    acc_new = state.acc;
    rem_new = state.remaining;
    if (state.remaining == REM_NONE) begin
      if (!in_byte[7] || (top < NIB_TWO_BYTE)) begin
        acc_new = {9'd0, in_byte[6:0]};
        rem_new = REM_NONE;
        done    = 1'b1;
      end else if (top < NIB_THREE_BYTE) begin
        acc_new = {10'd0, in_byte[5:0]};
        rem_new = REM_ONE;
      end else if (top == NIB_THREE_BYTE) begin
        acc_new = {11'd0, in_byte[4:0]};
        rem_new = REM_TWO;
      end else begin
        acc_new = {12'd0, in_byte[3:0]};
        rem_new = REM_THREE;
      end
    end else begin
      acc_new = {state.acc[9:0], in_byte[5:0]};
      rem_new = state.remaining - 2'd1;
      done    = (state.remaining == REM_ONE);
    end
  end

  // Count two output bytes per completed unit, saturating at the limit.
  assign total_sum = {1'b0, state.total} + 19'd2;
  always_comb begin
    total_new = state.total;
    if (done) begin
      if (total_sum > {1'b0, SAT_LIMIT}) begin
        total_new = SAT_LIMIT;
      end else begin
        total_new = total_sum[17:0];
      end
    end
  end

  // Build the result item in the configured byte order.
  always_comb begin
    result.unit_valid    = done;
    result.first_byte    = 8'd0;
    result.second_byte   = 8'd0;
    result.end_of_buffer = last_in_buffer;
    result.byte_count    = total_new;
    if (done) begin
      result.first_byte  = big_endian ? acc_new[15:8] : acc_new[7:0];
      result.second_byte = big_endian ? acc_new[7:0]  : acc_new[15:8];
    end
  end

  // A completed unit clears the accumulator; the buffer end clears everything.
  always_comb begin
    state_next.remaining = rem_new;
    state_next.acc       = done ? 16'd0 : acc_new;
    state_next.total     = total_new;
    if (last_in_buffer) begin
      state_next.remaining = REM_NONE;
      state_next.acc       = 16'd0;
      state_next.total     = 18'd0;
    end
  end

endmodule

### hw/rtl/utf8_to_utf16_bytes_core.sv
// Each accepted byte's result item is registered in the output register.
// Throughput: one byte per cycle while the input is not stalled; the decoder state updates on every transaction.
// The single output register holds a result while the sink stalls, and the input
// stalls only while that register is full and not being drained.
// Reset (rst, synchronous) clears the decoder state and count, empties the output
// register and sets big-endian output order.
module utf8_to_utf16_bytes_core
  import u8u16_pkg::*;
#(
  parameter int unsigned MAX_BUFFER_BYTES = DEFAULT_MAX_BUFFER_BYTES
)
(
  input  logic        clk,
  input  logic        rst,
  u8u16_in_if.sink    in_ch,
  u8u16_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_data
);

  localparam logic [17:0] SAT_LIMIT = count_limit(MAX_BUFFER_BYTES);

  u8u16_state_t  state;
  u8u16_state_t  state_next;
  u8u16_result_t step_result;
  u8u16_result_t result;
  logic          big_endian;
  logic          out_valid;
  logic          in_fire;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  u8u16_decode #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_decode (
    .state          (state),
    .in_byte        (in_ch.in_byte),
    .last_in_buffer (in_ch.last_in_buffer),
    .big_endian     (big_endian),
    .state_next     (state_next),
    .result         (step_result)
  );

  // Byte order register.
  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b1;
    end else if (cfg_we) begin
      big_endian <= cfg_data;
    end
  end

  // Decoder state advances on each input transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= step_result;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.unit_valid    = result.unit_valid;
  assign out_ch.first_byte    = result.first_byte;
  assign out_ch.second_byte   = result.second_byte;
  assign out_ch.end_of_buffer = result.end_of_buffer;
  assign out_ch.byte_count    = result.byte_count;

  // A buffer end leaves the decoder waiting for a lead byte with a zero count.
  a_buffer_end_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_ch.last_in_buffer |=> state == '0)
    else $error("decoder state not cleared after buffer end");

  // An item that completed no unit carries zero bytes.
  a_idle_bytes_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.unit_valid |-> result.first_byte == 8'd0 && result.second_byte == 8'd0)
    else $error("output bytes set without a completed unit");

  // The running count never passes its saturation limit.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    state.total <= SAT_LIMIT)
    else $error("running byte total above limit");

  // A full, stalled output register blocks the input.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |-> !in_fire)
    else $error("input accepted over an unread result");

  // The accumulator is empty whenever no sequence is open.
  a_acc_empty: assert property (@(posedge clk) disable iff (rst)
    state.remaining == REM_NONE |-> state.acc == 16'd0)
    else $error("accumulator holds bits with no open sequence");

endmodule
